### rtl/spq_pkg.sv
// Shared types and constants of the sorted priority queue.
package spq_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned TAG_BITS  = 16;
  localparam int unsigned PRIO_BITS = 8;
  localparam int unsigned CNT_BITS  = $clog2(DEPTH + 1);

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_type_e;

  typedef struct packed {
    logic [TAG_BITS-1:0]  tag;
    logic [PRIO_BITS-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

### rtl/spq_cell.sv
// One slot of the sorted chain: holds an entry, shifts back on insert, forward on remove.
module spq_cell import spq_pkg::*; (
  input  logic      clk_i,
  input  cell_ctl_t ctl_i,
  input  logic      occ_i,
  input  logic      place_left_i,
  input  entry_t    new_i,
  input  entry_t    left_i,
  input  entry_t    right_i,
  output logic      place_o,
  output entry_t    entry_o
);

  entry_t entry_q;
  entry_t entry_d;

  assign place_o = !occ_i || (entry_q.prio < new_i.prio);

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins && place_o) begin
      entry_d = place_left_i ? left_i : new_i;
    end else if (ctl_i.rem) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

### rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: cell chain, entry count and response register.
//
// Request channel (req_valid_i / req_ready_o) carries req_type_i, entry_tag_i and
// entry_priority_i. An insert places the entry behind every held entry of equal or
// higher priority; a remove pops the front entry. Every request yields exactly one
// response on the rsp_valid_o / rsp_ready_i channel with popped_valid_o, popped_tag_o,
// popped_priority_o, insert_refused_o and entry_count_o (count after the request).
//
// The response is registered at the edge that accepts the request. The queue takes
// one request per cycle while the receiver takes each response; every cell of the
// chain compares its priority against the new entry and shifts in the same cycle.
// An insert on a full queue leaves it unchanged and sets insert_refused_o; a remove
// on an empty queue returns popped_valid_o low with zero tag and priority.
// Reset empties the queue and clears the response valid flag. While the receiver
// stalls with a response pending, req_ready_o drops and the queue holds.
module sorted_priority_queue import spq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  logic                 req_type_i,
  input  logic [TAG_BITS-1:0]  entry_tag_i,
  input  logic [PRIO_BITS-1:0] entry_priority_i,
  output logic                 rsp_valid_o,
  input  logic                 rsp_ready_i,
  output logic                 popped_valid_o,
  output logic [TAG_BITS-1:0]  popped_tag_o,
  output logic [PRIO_BITS-1:0] popped_priority_o,
  output logic                 insert_refused_o,
  output logic [CNT_BITS-1:0]  entry_count_o
);

  logic [CNT_BITS-1:0]  count_q, count_d;
  logic                 rsp_valid_q;
  logic                 popped_valid_q, popped_valid_d;
  logic [TAG_BITS-1:0]  popped_tag_q, popped_tag_d;
  logic [PRIO_BITS-1:0] popped_prio_q, popped_prio_d;
  logic                 refused_q, refused_d;

  logic      accept;
  logic      is_full;
  logic      is_empty;
  cell_ctl_t ctl;
  entry_t    new_entry;
  entry_t    cell_entry [DEPTH];
  logic      cell_place [DEPTH];

  assign req_ready_o = !rsp_valid_q || rsp_ready_i;
  assign accept      = req_valid_i && req_ready_o;
  assign is_full     = (count_q == CNT_BITS'(DEPTH));
  assign is_empty    = (count_q == '0);

  assign new_entry.tag  = entry_tag_i;
  assign new_entry.prio = entry_priority_i;

  assign ctl.ins = accept && (req_type_e'(req_type_i) == REQ_INSERT) && !is_full;
  assign ctl.rem = accept && (req_type_e'(req_type_i) == REQ_REMOVE) && !is_empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   place_left;
    entry_t left_entry;
    entry_t right_entry;
    if (i == 0) begin : g_head
      assign place_left = 1'b0;
      assign left_entry = new_entry;
    end else begin : g_body
      assign place_left = cell_place[i-1];
      assign left_entry = cell_entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end
    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .occ_i        (count_q > CNT_BITS'(i)),
      .place_left_i (place_left),
      .new_i        (new_entry),
      .left_i       (left_entry),
      .right_i      (right_entry),
      .place_o      (cell_place[i]),
      .entry_o      (cell_entry[i])
    );
  end

  always_comb begin
    count_d        = count_q;
    popped_valid_d = 1'b0;
    popped_tag_d   = '0;
    popped_prio_d  = '0;
    refused_d      = 1'b0;
    unique case (req_type_e'(req_type_i))
      REQ_INSERT: begin
        if (is_full) begin
          refused_d = 1'b1;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (!is_empty) begin
          count_d        = count_q - 1'b1;
          popped_valid_d = 1'b1;
          popped_tag_d   = cell_entry[0].tag;
          popped_prio_d  = cell_entry[0].prio;
        end
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      popped_valid_q <= popped_valid_d;
      popped_tag_q   <= popped_tag_d;
      popped_prio_q  <= popped_prio_d;
      refused_q      <= refused_d;
    end
  end

  assign rsp_valid_o       = rsp_valid_q;
  assign popped_valid_o    = popped_valid_q;
  assign popped_tag_o      = popped_tag_q;
  assign popped_priority_o = popped_prio_q;
  assign insert_refused_o  = refused_q;
  assign entry_count_o     = count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_BITS'(DEPTH))
    else $error("entry count exceeds depth");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.ins |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow the count");

  a_refused_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && insert_refused_o |-> entry_count_o == CNT_BITS'(DEPTH))
    else $error("insert refused while not full");

  a_excl_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !(popped_valid_o && insert_refused_o))
    else $error("pop and refusal in one response");

  a_front_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= CNT_BITS'(2) |-> cell_entry[0].prio >= cell_entry[1].prio)
    else $error("front entries out of order");

endmodule

### dv/spq_response_check.sv
// Request/response monitor of the sorted priority queue: predicts every response and compares.
module spq_response_check import spq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  input  logic                 req_ready_i,
  input  logic                 req_type_i,
  input  logic [TAG_BITS-1:0]  entry_tag_i,
  input  logic [PRIO_BITS-1:0] entry_priority_i,
  input  logic                 rsp_valid_i,
  input  logic                 rsp_ready_i,
  input  logic                 popped_valid_i,
  input  logic [TAG_BITS-1:0]  popped_tag_i,
  input  logic [PRIO_BITS-1:0] popped_priority_i,
  input  logic                 insert_refused_i,
  input  logic [CNT_BITS-1:0]  entry_count_i,
  output int                   error_cnt_o,
  output int                   pending_o,
  output int                   request_cnt_o,
  output int                   response_cnt_o,
  output int                   refused_cnt_o,
  output int                   empty_pop_cnt_o
);

  typedef struct packed {
    logic                 popped_valid;
    logic [TAG_BITS-1:0]  popped_tag;
    logic [PRIO_BITS-1:0] popped_priority;
    logic                 insert_refused;
    logic [CNT_BITS-1:0]  entry_count;
  } queue_rsp_t;

  entry_t     held_entries[$];
  queue_rsp_t expected_rsps[$];

  function automatic queue_rsp_t queue_response(input req_type_e            kind,
                                                input logic [TAG_BITS-1:0]  tag,
                                                input logic [PRIO_BITS-1:0] prio);
    queue_rsp_t rsp;
    entry_t     ent;
    int         pos;
    int         i;
    rsp = '0;
    if (kind == REQ_INSERT) begin
      if (held_entries.size() >= DEPTH) begin
        rsp.insert_refused = 1'b1;
        refused_cnt_o++;
      end else begin
        // place behind every entry of equal or higher priority, head included
        pos = held_entries.size();
        for (i = 0; i < held_entries.size(); i++) begin
          if (pos == held_entries.size() && held_entries[i].prio < prio) begin
            pos = i;
          end
        end
        ent.tag  = tag;
        ent.prio = prio;
        held_entries.insert(pos, ent);
      end
    end else begin
      if (held_entries.size() == 0) begin
        empty_pop_cnt_o++;
      end else begin
        ent = held_entries.pop_front();
        rsp.popped_valid    = 1'b1;
        rsp.popped_tag      = ent.tag;
        rsp.popped_priority = ent.prio;
      end
    end
    rsp.entry_count = CNT_BITS'(held_entries.size());
    return rsp;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      error_cnt_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    queue_rsp_t exp_rsp;
    if (!rst_ni) begin
      held_entries.delete();
      expected_rsps.delete();
      error_cnt_o     = 0;
      request_cnt_o   = 0;
      response_cnt_o  = 0;
      refused_cnt_o   = 0;
      empty_pop_cnt_o = 0;
    end else begin
      if (req_valid_i && req_ready_i) begin
        expected_rsps.push_back(queue_response(req_type_e'(req_type_i), entry_tag_i,
                                               entry_priority_i));
        request_cnt_o++;
      end
      if (rsp_valid_i && rsp_ready_i) begin
        response_cnt_o++;
        if (expected_rsps.size() == 0) begin
          $display("%0t: response with no request outstanding, expected none, got count %0d",
                   $time, entry_count_i);
          error_cnt_o++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          compare_field("popped_valid", 32'(exp_rsp.popped_valid), 32'(popped_valid_i));
          compare_field("popped_tag", 32'(exp_rsp.popped_tag), 32'(popped_tag_i));
          compare_field("popped_priority", 32'(exp_rsp.popped_priority),
                        32'(popped_priority_i));
          compare_field("insert_refused", 32'(exp_rsp.insert_refused),
                        32'(insert_refused_i));
          compare_field("entry_count", 32'(exp_rsp.entry_count), 32'(entry_count_i));
        end
      end
    end
    pending_o = expected_rsps.size();
  end

endmodule

### dv/sorted_priority_queue_test.sv
// Testbench top of the sorted priority queue: clock, reset, request stimulus and verdict.
module sorted_priority_queue_test;
  import spq_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 120;
  localparam int unsigned PHASE_ITEMS     = 275;

  logic                 clk_i;
  logic                 rst_ni           = 1'b0;
  logic                 req_valid_i      = 1'b0;
  logic                 req_ready_o;
  logic                 req_type_i       = 1'b0;
  logic [TAG_BITS-1:0]  entry_tag_i      = '0;
  logic [PRIO_BITS-1:0] entry_priority_i = '0;
  logic                 rsp_valid_o;
  logic                 rsp_ready_i      = 1'b0;
  logic                 popped_valid_o;
  logic [TAG_BITS-1:0]  popped_tag_o;
  logic [PRIO_BITS-1:0] popped_priority_o;
  logic                 insert_refused_o;
  logic [CNT_BITS-1:0]  entry_count_o;

  int          error_cnt;
  int          pending;
  int          request_cnt;
  int          response_cnt;
  int          refused_cnt;
  int          empty_pop_cnt;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_cycles   = 0;
  int unsigned idle_cycles   = 0;

  sorted_priority_queue DUT (
    .clk_i,
    .rst_ni,
    .req_valid_i,
    .req_ready_o,
    .req_type_i,
    .entry_tag_i,
    .entry_priority_i,
    .rsp_valid_o,
    .rsp_ready_i,
    .popped_valid_o,
    .popped_tag_o,
    .popped_priority_o,
    .insert_refused_o,
    .entry_count_o
  );

  spq_response_check response_check (
    .clk_i,
    .rst_ni,
    .req_valid_i,
    .req_ready_i       (req_ready_o),
    .req_type_i,
    .entry_tag_i,
    .entry_priority_i,
    .rsp_valid_i       (rsp_valid_o),
    .rsp_ready_i,
    .popped_valid_i    (popped_valid_o),
    .popped_tag_i      (popped_tag_o),
    .popped_priority_i (popped_priority_o),
    .insert_refused_i  (insert_refused_o),
    .entry_count_i     (entry_count_o),
    .error_cnt_o       (error_cnt),
    .pending_o         (pending),
    .request_cnt_o     (request_cnt),
    .response_cnt_o    (response_cnt),
    .refused_cnt_o     (refused_cnt),
    .empty_pop_cnt_o   (empty_pop_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // stall the response side; a long hold-off overrides the random stalls
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        rsp_ready_i <= 1'b0;
        hold_cycles--;
      end else begin
        rsp_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("%0t: no handshake for %0d cycles, %0d responses outstanding",
             $time, WATCHDOG_LIMIT, pending);
    $display("** sorted_priority_queue: FAILED **");
    $finish;
  end

  function automatic logic [PRIO_BITS-1:0] random_priority();
    case ($urandom_range(3))
      0:       return PRIO_BITS'($urandom_range(3));
      1:       return $urandom_range(1) ? '1 : '0;
      default: return PRIO_BITS'($urandom());
    endcase
  endfunction

  task automatic send_request(input req_type_e            kind,
                              input logic [TAG_BITS-1:0]  tag,
                              input logic [PRIO_BITS-1:0] prio);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    req_valid_i      <= 1'b1;
    req_type_i       <= kind;
    entry_tag_i      <= tag;
    entry_priority_i <= prio;
    @(posedge clk_i);
    while (!req_ready_o) @(posedge clk_i);
  endtask

  task automatic wait_until_drained();
    req_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall);
    int unsigned stop_at;
    int unsigned mode;
    req_type_e   kind;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    stop_at       = request_cnt + PHASE_ITEMS;
    while (request_cnt < stop_at) begin
      mode = $urandom_range(3);
      repeat ($urandom_range(10, 24)) begin
        case (mode)
          0:       kind = REQ_INSERT;
          1:       kind = REQ_REMOVE;
          default: kind = $urandom_range(1) ? REQ_REMOVE : REQ_INSERT;
        endcase
        send_request(kind, TAG_BITS'($urandom()), random_priority());
      end
    end
    wait_until_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty pop, extremes, a new head, equal-priority order, then drain past empty
    send_request(REQ_REMOVE, 16'hffff, 8'hff);
    send_request(REQ_INSERT, 16'h0000, 8'h00);
    send_request(REQ_INSERT, 16'hffff, 8'hff);
    send_request(REQ_INSERT, 16'h1234, 8'h80);
    send_request(REQ_INSERT, 16'h5678, 8'h80);
    send_request(REQ_INSERT, 16'h9abc, 8'h80);
    send_request(REQ_INSERT, 16'h4321, 8'h81);
    send_request(REQ_INSERT, 16'ha5a5, 8'h00);
    send_request(REQ_INSERT, 16'h5a5a, 8'hff);
    repeat (9) send_request(REQ_REMOVE, 16'h0000, 8'h00);
    wait_until_drained();

    // hold the response side, then let inserts run on past full
    hold_cycles = HOLD_OFF_CYCLES;
    repeat (30) send_request(REQ_INSERT, TAG_BITS'($urandom()), random_priority());
    wait_until_drained();
    repeat (20) send_request(REQ_REMOVE, TAG_BITS'($urandom()), random_priority());
    wait_until_drained();

    run_phase(0, 0);
    run_phase(88, 0);
    run_phase(0, 88);
    run_phase(30, 30);

    repeat (5) @(posedge clk_i);
    $display("Sent %0d requests and checked %0d responses across four idle/stall mixes,",
             request_cnt, response_cnt);
    $display("including %0d refused inserts on a full queue and %0d removes on an empty one.",
             refused_cnt, empty_pop_cnt);
    if (error_cnt == 0 && pending == 0) begin
      $display("** sorted_priority_queue: PASSED **");
    end else begin
      $display("** sorted_priority_queue: FAILED **");
    end
    $finish;
  end

endmodule
